[rtl/opvd_pkg.sv]
`timescale 1ns / 1ps

package opvd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned LenWidth   = 4;

   // lead byte classes
   localparam logic [ByteWidth-1:0] PosLeadBase   = 8'd247;  // above: positive length code
   localparam logic [ByteWidth-1:0] NegLeadLimit  = 8'd8;    // below: negative length code
   localparam logic [ByteWidth-1:0] DirectOffset  = 8'd48;

   // leading content byte limits
   localparam logic [ByteWidth-1:0] OnePosMaxBad  = 8'd199;
   localparam logic [ByteWidth-1:0] OneNegMinBad  = 8'd216;
   localparam logic [ByteWidth-1:0] ByteZero      = 8'h00;
   localparam logic [ByteWidth-1:0] ByteOnes      = 8'hFF;
   localparam logic [LenWidth-1:0]  LenOne        = 4'd1;
   localparam logic [LenWidth-1:0]  LenFull       = 4'd8;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_LEAD = 3'd1,
      ST_NONCANON = 3'd2,
      ST_RANGE    = 3'd3,
      ST_TRUNC    = 3'd4
   } status_type;

endpackage

[rtl/order_preserving_varint_decoder.sv]
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | req_byte_value[7:0], req_stream_end
// rsp     | out       | rsp_valid/rsp_stall | rsp_value[63:0], rsp_status[2:0]
// csr     | in        | csr_wr_en           | csr_wr_data (signed_mode)
//
// One request per cycle while req_stall is low. A result appears in the output
// register in the cycle after the request that completes it; decode state and
// output register are updated in the same edge. req_stall is high only while a
// result is held and rsp_stall is high. Synchronous active-high reset clears
// decode state, empties the output register and sets signed mode.

module order_preserving_varint_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_stream_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value,
   output logic [2:0]  rsp_status
);
   import opvd_pkg::*;

   logic                  signed_mode_ff;
   logic                  collecting_ff,  collecting_in;
   logic [LenWidth-1:0]   total_len_ff,   total_len_in;
   logic [LenWidth-1:0]   bytes_left_ff,  bytes_left_in;
   logic                  negative_ff,    negative_in;
   logic [ValueWidth-1:0] acc_ff,         acc_in;

   logic                  rsp_valid_ff;
   logic [ValueWidth-1:0] rsp_value_ff;
   status_type            rsp_status_ff;

   logic                  accept;
   logic                  emit;
   status_type            st;
   logic [ValueWidth-1:0] result;
   logic [ByteWidth:0]    direct_diff;
   logic [ValueWidth-1:0] acc_shift;
   logic [LenWidth-1:0]   left_dec;
   status_type            lead_st;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign accept     = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   assign direct_diff = {1'b0, req_byte_value} - {1'b0, DirectOffset};
   assign acc_shift   = {acc_ff[ValueWidth-ByteWidth-1:0], req_byte_value};
   assign left_dec    = bytes_left_ff - LenOne;

   // checks on the first content byte
   always_comb begin
      lead_st = ST_OK;
      if (negative_ff) begin
         priority if (total_len_ff == LenOne) begin
            if (req_byte_value >= OneNegMinBad) lead_st = ST_NONCANON;
         end else if (total_len_ff == LenFull && !req_byte_value[ByteWidth-1]) begin
            lead_st = ST_RANGE;
         end else if (req_byte_value == ByteOnes) begin
            lead_st = ST_NONCANON;
         end else begin
            lead_st = ST_OK;
         end
      end else begin
         priority if (total_len_ff == LenOne) begin
            if (req_byte_value <= OnePosMaxBad) lead_st = ST_NONCANON;
         end else if (signed_mode_ff && total_len_ff == LenFull &&
                      req_byte_value[ByteWidth-1]) begin
            lead_st = ST_RANGE;
         end else if (req_byte_value == ByteZero) begin
            lead_st = ST_NONCANON;
         end else begin
            lead_st = ST_OK;
         end
      end
   end

   always_comb begin
      collecting_in = collecting_ff;
      total_len_in  = total_len_ff;
      bytes_left_in = bytes_left_ff;
      negative_in   = negative_ff;
      acc_in        = acc_ff;
      emit          = 1'b0;
      st            = ST_OK;
      result        = '0;

      if (req_stream_end) begin
         if (collecting_ff) begin
            emit = 1'b1;
            st   = ST_TRUNC;
         end
      end else if (!collecting_ff) begin
         priority if (req_byte_value > PosLeadBase) begin
            collecting_in = 1'b1;
            total_len_in  = LenWidth'(req_byte_value - PosLeadBase);
            bytes_left_in = LenWidth'(req_byte_value - PosLeadBase);
            negative_in   = 1'b0;
            acc_in        = '0;
         end else if (signed_mode_ff) begin
            if (req_byte_value >= NegLeadLimit) begin
               emit   = 1'b1;
               result = {{(ValueWidth-ByteWidth-1){direct_diff[ByteWidth]}}, direct_diff};
            end else begin
               collecting_in = 1'b1;
               total_len_in  = LenWidth'(NegLeadLimit - req_byte_value);
               bytes_left_in = LenWidth'(NegLeadLimit - req_byte_value);
               negative_in   = 1'b1;
               acc_in        = '1;
            end
         end else if (req_byte_value < DirectOffset) begin
            emit = 1'b1;
            st   = ST_BAD_LEAD;
         end else begin
            emit   = 1'b1;
            result = {{(ValueWidth-ByteWidth){1'b0}}, direct_diff[ByteWidth-1:0]};
         end
      end else if (bytes_left_ff == total_len_ff && lead_st != ST_OK) begin
         emit = 1'b1;
         st   = lead_st;
      end else begin
         acc_in        = acc_shift;
         bytes_left_in = left_dec;
         if (left_dec == '0) begin
            emit   = 1'b1;
            result = acc_shift;
         end
      end

      // any result returns to waiting for a lead byte
      if (emit) begin
         collecting_in = 1'b0;
         total_len_in  = '0;
         bytes_left_in = '0;
         negative_in   = 1'b0;
         acc_in        = '0;
         if (st != ST_OK) result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         signed_mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         total_len_ff  <= '0;
         bytes_left_ff <= '0;
         negative_ff   <= 1'b0;
         acc_ff        <= '0;
      end else if (accept) begin
         collecting_ff <= collecting_in;
         total_len_ff  <= total_len_in;
         bytes_left_ff <= bytes_left_in;
         negative_ff   <= negative_in;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_value_ff  <= result;
         rsp_status_ff <= st;
      end
   end

endmodule
